// ===== rtl/ckt_pkg.sv =====
// Shared types and codes for the compacting keyed table.
// Entry and result records, operation and status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package ckt_pkg;

	localparam int CKT_DEFAULT_CAPACITY = 16;
	localparam int CKT_POS_W = 5;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_FIND   = 2'd2,
		FN_LIST   = 2'd3
	} ckt_func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} ckt_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_LIST
	} ckt_state_t;

	typedef struct packed {
		logic [63:0]        name;
		logic [63:0]        kind;
		logic signed [31:0] amount;
	} ckt_entry_t;

	typedef struct packed {
		ckt_status_t           status;
		ckt_entry_t            entry;
		logic [CKT_POS_W-1:0]  position;
		logic [CKT_POS_W-1:0]  fill;
		logic                  last;
	} ckt_result_t;

endpackage

// ===== rtl/ckt_mem.sv =====
// Entry memory: one write port, one read port with registered read data.
// Depends on ckt_pkg for the entry record.
`timescale 1ns / 1ps

module ckt_mem import ckt_pkg::*; #(
	parameter int DEPTH = CKT_DEFAULT_CAPACITY,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  ckt_entry_t       wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output ckt_entry_t       rd_data
);

	ckt_entry_t mem [DEPTH];
	ckt_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/compacting_keyed_table.sv =====
// Compacting keyed table: ordered entry table with insert, remove, find, list.
// Depends on ckt_pkg and ckt_mem (entry storage).
//
//   channel   signals                                   handshake
//   command   func key_name kind_tag amount             start, busy
//   result    status out_name out_kind out_amount       done (one cycle)
//             position fill_level last
//
// Insert and any operation on an empty table: result in the cycle after accept.
// Find and remove scan the entry memory one read a cycle; remove then shifts
// later entries down, one entry a cycle.
// List gives one result a cycle, from the first entry to the last.
// Reset clears the entry count; memory contents need no clearing.
// Results cannot be stalled; busy stays high until an item's last result.
`timescale 1ns / 1ps

module compacting_keyed_table import ckt_pkg::*; #(
	parameter int CAPACITY = CKT_DEFAULT_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [63:0]          key_name,
	input  logic [63:0]          kind_tag,
	input  logic signed [31:0]   amount,
	output logic                 done,
	output logic [1:0]           status,
	output logic [63:0]          out_name,
	output logic [63:0]          out_kind,
	output logic signed [31:0]   out_amount,
	output logic [4:0]           position,
	output logic [4:0]           fill_level,
	output logic                 last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EXT_W = CNT_W + CKT_POS_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	ckt_state_t         state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   scan_q, scan_d;
	logic               pend_q, pend_d;
	logic [CNT_W-1:0]   pend_idx_q, pend_idx_d;
	logic               done_q, done_d;
	ckt_result_t        res_q, res_d;
	ckt_func_t          func_q;
	logic [63:0]        key_q;

	logic               rd_en, wr_en;
	logic [CNT_W-1:0]   rd_idx, wr_idx;
	ckt_entry_t         wr_data, rd_data, new_entry;
	logic               accept;

	function automatic logic [CKT_POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[CKT_POS_W-1:0];
	endfunction

	assign accept = start && (state_q == S_IDLE);
	assign new_entry = '{name: key_name, kind: kind_tag, amount: amount};

	ckt_mem #(
		.DEPTH (CAPACITY),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_idx[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q  <= scan_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_q <= pend_idx_d;
		res_q      <= res_d;
		if (accept) begin
			func_q <= ckt_func_t'(func);
			key_q  <= key_name;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		scan_d     = scan_q;
		pend_d     = 1'b0;
		pend_idx_d = scan_q;
		done_d     = 1'b0;
		res_d      = res_q;
		rd_en      = 1'b0;
		rd_idx     = scan_q;
		wr_en      = 1'b0;
		wr_idx     = count_q;
		wr_data    = rd_data;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (func == FN_INSERT) begin
						done_d = 1'b1;
						if (count_q >= CAP_C) begin
							res_d = '{status: ST_FULL, entry: '0, position: '0,
								fill: to_pos(count_q), last: 1'b1};
						end else begin
							wr_en   = 1'b1;
							wr_data = new_entry;
							count_d = count_q + ONE_C;
							res_d = '{status: ST_OK, entry: new_entry,
								position: to_pos(count_q + ONE_C),
								fill: to_pos(count_q + ONE_C), last: 1'b1};
						end
					end else if (count_q == '0) begin
						done_d = 1'b1;
						res_d = '{status: ST_EMPTY, entry: '0, position: '0,
							fill: '0, last: 1'b1};
					end else begin
						scan_d  = '0;
						state_d = (func == FN_LIST) ? S_LIST : S_SCAN;
					end
				end
			end

			S_SCAN: begin
				if (scan_q < count_q) begin
					rd_en  = 1'b1;
					scan_d = scan_q + ONE_C;
					pend_d = 1'b1;
				end
				if (pend_q) begin
					if (rd_data.name == key_q) begin
						res_d = '{status: ST_OK, entry: rd_data,
							position: to_pos(pend_idx_q + ONE_C),
							fill: to_pos(count_q), last: 1'b1};
						if (func_q == FN_FIND) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							scan_d  = pend_idx_q + ONE_C;
							pend_d  = 1'b0;
							state_d = S_SHIFT;
						end
					end else if (pend_idx_q == count_q - ONE_C) begin
						done_d  = 1'b1;
						res_d = '{status: ST_MISSING, entry: '0, position: '0,
							fill: to_pos(count_q), last: 1'b1};
						state_d = S_IDLE;
					end
				end
			end

			S_SHIFT: begin
				if (pend_q) begin
					wr_en  = 1'b1;
					wr_idx = pend_idx_q - ONE_C;
				end
				if (scan_q < count_q) begin
					rd_en  = 1'b1;
					scan_d = scan_q + ONE_C;
					pend_d = 1'b1;
				end else begin
					count_d    = count_q - ONE_C;
					res_d.fill = to_pos(count_q - ONE_C);
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end
			end

			S_LIST: begin
				if (scan_q < count_q) begin
					rd_en  = 1'b1;
					scan_d = scan_q + ONE_C;
					pend_d = 1'b1;
				end
				if (pend_q) begin
					done_d = 1'b1;
					res_d = '{status: ST_OK, entry: rd_data,
						position: to_pos(pend_idx_q + ONE_C),
						fill: to_pos(count_q),
						last: (pend_idx_q == count_q - ONE_C)};
					if (pend_idx_q == count_q - ONE_C) begin
						state_d = S_IDLE;
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = res_q.status;
	assign out_name   = res_q.entry.name;
	assign out_kind   = res_q.entry.kind;
	assign out_amount = res_q.entry.amount;
	assign position   = res_q.position;
	assign fill_level = res_q.fill;
	assign last       = res_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FN_INSERT && count_q < CAP_C)
		|=> (done_q && count_q == $past(count_q) + ONE_C))
		else $error("insert did not add an entry");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHIFT || accept))
		else $error("memory write outside insert or shift");

	a_shift_read_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_idx == wr_idx + ONE_C + ONE_C))
		else $error("shift read overlaps write");

	a_miss_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status != ST_OK) |-> (res_q.position == '0 && res_q.last))
		else $error("error result carries an entry");

endmodule
